### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and held off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the step peak detector.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int FRAC_BITS  = 8;   // baseline fraction bits
    localparam int CNT_W      = 16;  // calibration count width
    localparam int THR_W      = 17;  // signed threshold width
    localparam int IVL_W      = 16;  // min interval width
    localparam int TIME_W     = 32;  // timestamp width
    localparam int BASE_OUT_W = 16;  // reported baseline width
    localparam int HIST_DEPTH = 3;   // deviation history depth

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [1:0]              cfg_idx_t;
    typedef logic signed [THR_W-1:0] thr_t;
    typedef logic [IVL_W-1:0]        ivl_t;
    typedef logic [TIME_W-1:0]       time_t;

    // register map
    localparam cfg_idx_t REG_UPPER_THR = 2'd0;
    localparam cfg_idx_t REG_LOWER_THR = 2'd1;
    localparam cfg_idx_t REG_MIN_IVL   = 2'd2;

    // reset values
    localparam thr_t RST_UPPER_THR = 17'sd4000;
    localparam thr_t RST_LOWER_THR = 17'sd500;
    localparam ivl_t RST_MIN_IVL   = 16'd300;

endpackage

### src/step_peak_detector.sv
// ----------------------------------------------------------------------------
// step_peak_detector
// Step detection by peak finding on acceleration magnitude samples.
// ----------------------------------------------------------------------------
// Each input item is a calibration sample (tuser = 0) or a detection sample
// (tuser = 1) and yields exactly one output item carrying the step flag and
// the integer part of the running-mean baseline after that item. Calibration
// items update the 16.8 baseline as avg += trunc(((sample << 8) - avg) / count)
// with a saturating count; the divide runs on one shared restoring divider,
// one quotient bit per cycle, so a calibration item passes through the
// prep, divide, apply and finish states from accept to output. Detection
// items shift the three-deep deviation history, test the middle entry for
// a strict local maximum inside the open threshold window, and report a step
// when the time since the previous qualifying peak reaches min_interval_ms.
// One item is in flight at a time; the output register lets the next item be
// accepted while a finished result still waits on m_tready. Configuration is
// written through cfg_wr_en / cfg_addr / cfg_wdata; the user must do so only
// while idle, not enforced by the block; writes to unused addresses are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module step_peak_detector
    import spd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    // slave side
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // [SAMPLE_WIDTH-1:0] accel_sample, then [31:0] time_ms, zero pad to bytes
    input  logic [((SAMPLE_WIDTH+TIME_W+7)/8)*8-1:0]  s_tdata,
    // [0] operation
    input  logic                                      s_tuser,
    // master side
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // [15:0] baseline_value
    output logic [BASE_OUT_W-1:0]                     m_tdata,
    // [0] step_detected
    output logic                                      m_tuser,
    // configuration write port
    input  logic                                      cfg_wr_en,
    input  cfg_idx_t                                  cfg_addr,
    input  logic [THR_W-1:0]                          cfg_wdata
);

    // widths
    localparam int AW  = SAMPLE_WIDTH + FRAC_BITS;      // baseline width
    localparam int QW  = AW + 1;                        // dividend / quotient
    localparam int DW  = SAMPLE_WIDTH + 1;              // deviation width
    localparam int CW  = (DW > THR_W) ? DW : THR_W;     // compare width
    localparam int BCW = $clog2(QW);                    // bit counter width
    localparam int BW  = (SAMPLE_WIDTH > TIME_W) ? SAMPLE_WIDTH : TIME_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_DET    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // control state
    logic [2:0]              state_reg, state_next;
    logic [BCW-1:0]          bit_reg, bit_next;
    logic                    op_reg, op_next;
    logic                    step_reg, step_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // architectural state
    logic [AW-1:0]           avg_reg, avg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    time_t                   last_reg, last_next;
    logic signed [DW-1:0]    hist_reg [HIST_DEPTH];
    logic signed [DW-1:0]    hist_next [HIST_DEPTH];

    // configuration
    thr_t                    upper_reg, lower_reg;
    ivl_t                    min_ivl_reg;

    // item payload and divider datapath
    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    time_t                   time_reg, time_next;
    logic [QW-1:0]           dvd_reg, dvd_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic [BASE_OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    // combinational helpers
    logic signed [QW-1:0]    diff;
    logic [CNT_W:0]          rem_sh;
    logic                    q_bit;
    logic [QW:0]             q_signed;
    logic [QW:0]             sum;
    logic [SAMPLE_WIDTH-1:0] avg_int;
    logic signed [DW-1:0]    dev;
    logic signed [CW-1:0]    peak_c, left_c, right_c, upper_c, lower_c;
    logic                    is_peak;
    time_t                   elapsed;
    logic [BW-1:0]           base_wide;
    logic                    out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign avg_int  = avg_reg[AW-1:FRAC_BITS];

    // signed difference of the scaled sample and the baseline
    assign diff = $signed({1'b0, sample_reg, {FRAC_BITS{1'b0}}}) - $signed({1'b0, avg_reg});

    // one restoring divide step
    assign rem_sh = {rem_reg, dvd_reg[QW-1]};
    assign q_bit  = (rem_sh >= {1'b0, cnt_reg});

    // apply the signed quotient
    assign q_signed = neg_reg ? -{1'b0, dvd_reg} : {1'b0, dvd_reg};
    assign sum      = {2'b00, avg_reg} + q_signed;

    // peak test
    assign dev     = $signed({1'b0, sample_reg}) - $signed({1'b0, avg_int});
    assign peak_c  = CW'(hist_reg[2]);       // becomes the middle entry
    assign left_c  = CW'(hist_reg[1]);       // becomes the oldest entry
    assign right_c = CW'(dev);
    assign upper_c = CW'(upper_reg);
    assign lower_c = CW'(lower_reg);
    assign is_peak = (peak_c > left_c) && (peak_c > right_c) &&
                     (peak_c < upper_c) && (peak_c > lower_c);
    assign elapsed = time_reg - last_reg;

    assign base_wide = BW'(avg_int);

    always_comb
    begin
        state_next    = state_reg;
        bit_next      = bit_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        avg_next      = avg_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        sample_next   = sample_reg;
        time_next     = time_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    sample_next = s_tdata[SAMPLE_WIDTH-1:0];
                    time_next   = s_tdata[SAMPLE_WIDTH+TIME_W-1:SAMPLE_WIDTH];
                    step_next   = 1'b0;
                    if (s_tuser)
                    begin
                        state_next = ST_DET;
                    end
                    else
                    begin
                        if (cnt_reg != CNT_MAX)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                neg_next   = diff[QW-1];
                dvd_next   = diff[QW-1] ? -diff : diff;
                rem_next   = '0;
                bit_next   = BCW'(QW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = q_bit ? CNT_W'(rem_sh - {1'b0, cnt_reg}) : rem_sh[CNT_W-1:0];
                dvd_next = {dvd_reg[QW-2:0], q_bit};
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                avg_next   = sum[AW-1:0];
                state_next = ST_FINISH;
            end
            ST_DET:
            begin
                hist_next[0] = hist_reg[1];
                hist_next[1] = hist_reg[2];
                hist_next[2] = dev;
                if (is_peak)
                begin
                    last_next = time_reg;
                    step_next = (elapsed >= TIME_W'(min_ivl_reg));
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = base_wide[BASE_OUT_W-1:0];
                    m_tuser_next  = step_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_reg      <= '0;
            op_reg       <= 1'b0;
            step_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            avg_reg      <= '0;
            cnt_reg      <= '0;
            last_reg     <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            bit_reg      <= bit_next;
            op_reg       <= op_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            avg_reg      <= avg_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg   <= RST_UPPER_THR;
            lower_reg   <= RST_LOWER_THR;
            min_ivl_reg <= RST_MIN_IVL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_UPPER_THR: upper_reg   <= cfg_wdata;
                REG_LOWER_THR: lower_reg   <= cfg_wdata;
                REG_MIN_IVL:   min_ivl_reg <= cfg_wdata[IVL_W-1:0];
                default:       ;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        time_reg    <= time_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // checks
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLIES(a_cal_no_step, state_reg == ST_FINISH && !op_reg, !step_reg)
    `ASSERT_IMPLIES(a_rem_below_div, state_reg == ST_DIV, rem_reg < cnt_reg)
    `ASSERT_NEXT(a_cnt_monotonic, 1'b1, cnt_reg >= $past(cnt_reg))
    `ASSERT_NEXT(a_det_keeps_avg, state_reg == ST_DET, $stable(avg_reg))

endmodule

### sim/step_peak_detector_test.sv
// ----------------------------------------------------------------------------
// step_peak_detector_test
// Self-checking bench for the step peak detector. Calibration and detection
// samples go in on the slave stream, step flag and baseline come back on the
// master stream. A scoreboard tracks baseline, deviation history and last peak
// time on its own and checks every output item in order. Both stream sides
// idle at random, the receiver holds off once for a long stretch, and the
// threshold window and minimum interval change between idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module step_peak_detector_test;
    import spd_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int TDATA_W  = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
    localparam int AVG_W    = SAMPLE_W + FRAC_BITS;

    // item kinds on s_tuser
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_DETECT    = 1'b1;

    // address with no register behind it, writes must be dropped
    localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3);

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 40;    // extra wait after the last output item
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int PRINT_CAP      = 100;   // keep the log short on a bad run
    localparam int PHASE_ITEMS    = 95;

    typedef struct packed
    {
        logic                  step;
        logic [BASE_OUT_W-1:0] baseline;
    } step_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the detector state, queue of due output items
    // ------------------------------------------------------------------------
    class step_ledger;
        thr_t               upper_thr;
        thr_t               lower_thr;
        ivl_t               min_ivl;
        thr_t               deviation [HIST_DEPTH];
        logic [AVG_W-1:0]   avg_fix;      // 16.8 running mean
        logic [CNT_W-1:0]   cal_count;
        time_t              last_peak;
        step_report_t       due_reports [$];
        int                 mismatches;

        function new();
            upper_thr  = RST_UPPER_THR;
            lower_thr  = RST_LOWER_THR;
            min_ivl    = RST_MIN_IVL;
            foreach (deviation[i])
                deviation[i] = '0;
            avg_fix    = '0;
            cal_count  = '0;
            last_peak  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [THR_W-1:0] value);
            case (idx)
                REG_UPPER_THR: upper_thr = thr_t'(value);
                REG_LOWER_THR: lower_thr = thr_t'(value);
                REG_MIN_IVL:   min_ivl   = value[IVL_W-1:0];
                default:       ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // one accepted input item -> one due output item
        function void accept_sample(logic op, logic [SAMPLE_W-1:0] sample, time_t now);
            longint       diff;
            time_t        elapsed;
            step_report_t r;
            r.step = 1'b0;
            if (op == OP_CALIBRATE)
            begin
                if (cal_count != CNT_MAX)
                    cal_count++;
                // signed divide, truncates toward zero
                diff    = longint'({sample, 8'h00}) - longint'(avg_fix);
                diff    = diff / longint'(cal_count);
                avg_fix = AVG_W'(longint'(avg_fix) + diff);
            end
            else
            begin
                deviation[0] = deviation[1];
                deviation[1] = deviation[2];
                deviation[2] = thr_t'(longint'(sample)
                                      - longint'(avg_fix[AVG_W-1:FRAC_BITS]));
                elapsed = now - last_peak;   // wraps mod 2^32
                if (deviation[1] > deviation[0] && deviation[1] > deviation[2] &&
                    deviation[1] < upper_thr && deviation[1] > lower_thr)
                begin
                    last_peak = now;
                    if (elapsed >= min_ivl)
                        r.step = 1'b1;
                end
            end
            r.baseline = avg_fix[AVG_W-1:FRAC_BITS];
            due_reports.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task match_report(logic step, logic [BASE_OUT_W-1:0] baseline);
            step_report_t r;
            if (due_reports.size() == 0)
            begin
                report_mismatch("output item with nothing pending, baseline", baseline, 0);
            end
            else
            begin
                r = due_reports.pop_front();
                if (step !== r.step)
                    report_mismatch("step_detected", step, r.step);
                if (baseline !== r.baseline)
                    report_mismatch("baseline_value", baseline, r.baseline);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // [15:0] accel_sample, [47:16] time_ms
    logic                  s_tuser   = 1'b0; // [0] operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BASE_OUT_W-1:0] m_tdata;          // [15:0] baseline_value
    logic                  m_tuser;          // [0] step_detected
    logic                  cfg_wr_en = 1'b0;
    cfg_idx_t              cfg_addr  = REG_UPPER_THR;
    logic [THR_W-1:0]      cfg_wdata = '0;

    step_ledger ledger = new();

    bit    no_idle      = 1'b0;  // both sides run flat out while set
    bit    hold_request = 1'b0;  // asks the receiver for one long hold-off
    time_t clock_ms     = '0;    // timestamp for detection items, advanced per item
    int    quiet_cycles = 0;

    always #5 clk = ~clk;

    step_peak_detector #(.SAMPLE_WIDTH(SAMPLE_W)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Monitor: samples both handshakes at the edge (pre-update values), feeds
    // the scoreboard and runs the no-progress watchdog.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                ledger.match_report(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                ledger.accept_sample(s_tuser, s_tdata[SAMPLE_W-1:0],
                                     s_tdata[SAMPLE_W +: TIME_W]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return SAMPLE_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random gap before each output item, one long hold on request.
    // m_tready gets a single assignment per edge.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            if (hold_request)
            begin
                // block fills up behind this, sender keeps offering
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // offers one item after a random gap, returns at the accepting edge;
    // s_tvalid stays high into the next item when that gap is zero
    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] sample,
                             input time_t stamp);
        int                 gap;
        logic [TDATA_W-1:0] word;
        gap  = draw_gap();
        word = '0;
        word[SAMPLE_W-1:0]       = sample;
        word[SAMPLE_W +: TIME_W] = stamp;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering and wait until every output item is back and the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; wr_en is left high so writes can go back to back
    task automatic put_reg(input cfg_idx_t idx, input logic [THR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        ledger.write_reg(idx, value);
    endtask

    // full register set, plus a junk write to the unused address
    task automatic load_config(input int upper, input int lower, input int min_ivl);
        put_reg(REG_UPPER_THR, THR_W'(upper));
        put_reg(REG_LOWER_THR, THR_W'(lower));
        // bit 16 is not part of the interval register
        put_reg(REG_MIN_IVL, {1'($urandom_range(0, 1)), IVL_W'(min_ivl)});
        put_reg(REG_UNUSED, THR_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // random window around zero deviation, upper bound always above lower
    task automatic load_random_window(input int ivl_max);
        int lower;
        lower = int'($urandom_range(0, 6000)) - 3000;
        load_config(lower + int'($urandom_range(1, 6000)), lower, $urandom_range(0, ivl_max));
    endtask

    // Mostly host-like traffic: a calibration burst around some level, then a
    // detection run wandering around the current baseline so peaks land in
    // and out of the window, then a little fully random noise.
    task automatic run_phase(input int quota, input bit squeeze);
        int sent;
        int burst;
        int level;
        int dev;
        sent = 0;
        while (sent < quota)
        begin
            level = $urandom_range(0, 65535);
            burst = $urandom_range(20, 40);
            repeat (burst)
            begin
                send_item(OP_CALIBRATE,
                          clamp_sample(level + int'($urandom_range(0, 4000)) - 2000),
                          time_t'($urandom));
                sent++;
            end
            if (squeeze)
            begin
                hold_request = 1'b1;
                squeeze      = 1'b0;
            end
            burst = $urandom_range(50, 100);
            repeat (burst)
            begin
                if ($urandom_range(0, 49) == 0)
                    clock_ms = time_t'($urandom);
                else
                    clock_ms += time_t'($urandom_range(1, 400));
                dev = int'($urandom_range(0, 11000)) - 6000;
                send_item(OP_DETECT,
                          clamp_sample(int'(ledger.avg_fix[AVG_W-1:FRAC_BITS]) + dev),
                          clock_ms);
                sent++;
            end
            burst = $urandom_range(5, 20);
            repeat (burst)
            begin
                send_item(1'($urandom), SAMPLE_W'($urandom), time_t'($urandom));
                sent++;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        int lower;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset register values, baseline still zero ---
        // detection before calibration: deviation equals the sample
        send_item(OP_DETECT, 16'd0,    32'd0);
        send_item(OP_DETECT, 16'd1000, 32'd100);
        send_item(OP_DETECT, 16'd200,  32'd200);   // peak, 200 ms only: no step
        send_item(OP_DETECT, 16'd1500, 32'd700);
        send_item(OP_DETECT, 16'd0,    32'd800);   // peak 600 ms later: step
        send_item(OP_DETECT, 16'hFFFF, 32'd900);
        send_item(OP_DETECT, 16'd0,    32'd1000);  // max sample over upper threshold
        // timestamp wrap
        send_item(OP_DETECT, 16'd100,  32'hFFFF_FF00);
        send_item(OP_DETECT, 16'd2000, 32'hFFFF_FFC0);
        send_item(OP_DETECT, 16'd100,  32'hFFFF_FFFF);
        send_item(OP_DETECT, 16'd3000, 32'h0000_0100);
        send_item(OP_DETECT, 16'd50,   32'h0000_012B); // exactly 300 ms across wrap
        // calibration extremes, falling diff truncates toward zero
        send_item(OP_CALIBRATE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_CALIBRATE, 16'd0,    32'd0);
        send_item(OP_CALIBRATE, 16'hFFFF, 32'h5555_5555);
        send_item(OP_CALIBRATE, 16'd0,    32'hAAAA_AAAA);
        send_item(OP_CALIBRATE, 16'd12345, 32'd7);
        settle();

        // inverted window: nothing qualifies
        load_config(500, 4000, 0);
        send_item(OP_DETECT, 16'd0,     32'd2000);
        send_item(OP_DETECT, 16'd50000, 32'd3000);
        send_item(OP_DETECT, 16'd0,     32'd4000);
        settle();

        // empty open window
        load_config(1001, 1000, 0);
        send_item(OP_DETECT, 16'd0,     32'd5000);
        send_item(OP_DETECT, 16'd21000, 32'd6000);
        send_item(OP_DETECT, 16'd0,     32'd7000);
        settle();

        // widest window, longest interval: peaks qualify, only a long gap steps
        load_config(65535, -65535, 65535);
        send_item(OP_DETECT, 16'd30000, 32'd8000);
        send_item(OP_DETECT, 16'd0,     32'd9000);
        send_item(OP_DETECT, 16'd40000, 32'd80000);
        send_item(OP_DETECT, 16'd0,     32'd80100);
        settle();

        // --- random phases ---
        clock_ms = 32'd100000;
        load_config(int'(RST_UPPER_THR), int'(RST_LOWER_THR), int'(RST_MIN_IVL));
        run_phase(PHASE_ITEMS, 1'b0);

        no_idle = 1'b1;
        load_config(65535, -65535, 0);
        run_phase(PHASE_ITEMS, 1'b0);
        no_idle = 1'b0;

        load_random_window(1000);
        run_phase(PHASE_ITEMS, 1'b0);

        load_config(65535, -65535, 65535);
        run_phase(PHASE_ITEMS, 1'b0);

        lower = $urandom_range(0, 3000);
        load_config(lower - int'($urandom_range(0, 3000)), lower, $urandom_range(0, 500));
        run_phase(PHASE_ITEMS, 1'b0);

        // long receiver hold-off in this one
        load_random_window(600);
        run_phase(PHASE_ITEMS, 1'b1);

        // negative-only window, timestamps running into the wrap
        clock_ms = 32'hFFFF_0000;
        load_config(0, -65535, $urandom_range(0, 65535));
        run_phase(PHASE_ITEMS, 1'b0);

        no_idle = 1'b1;
        load_random_window(1000);
        run_phase(PHASE_ITEMS, 1'b0);
        no_idle = 1'b0;

        load_random_window(600);
        run_phase(PHASE_ITEMS, 1'b0);

        // settle() inside the last phase already drained everything
        if (ledger.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
